// ===== rtl/rmr_pkg.sv =====
// Package for the register map read responder.
// Holds the action codes, the sequencer state type and the diagnostic reply text.
// No dependencies.
package rmr_pkg;

  localparam logic [3:0] ACT_RD_COIL  = 4'd0;
  localparam logic [3:0] ACT_RD_DISC  = 4'd1;
  localparam logic [3:0] ACT_RD_HOLD  = 4'd2;
  localparam logic [3:0] ACT_RD_INPUT = 4'd3;
  localparam logic [3:0] ACT_DIAG     = 4'd4;
  localparam logic [3:0] ACT_LD_COIL  = 4'd5;
  localparam logic [3:0] ACT_LD_DISC  = 4'd6;
  localparam logic [3:0] ACT_LD_HOLD  = 4'd7;
  localparam logic [3:0] ACT_LD_INPUT = 4'd8;

  localparam logic [2:0] DIAG_LAST = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_PRIME,
    ST_BITS,
    ST_WHI,
    ST_WLO,
    ST_DIAG
  } state_e;

  // byte count 8 followed by the text "All OK"
  function automatic logic [7:0] diag_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'd8;
      3'd1:    b = 8'h41;
      3'd2:    b = 8'h6C;
      3'd3:    b = 8'h6C;
      3'd4:    b = 8'h20;
      3'd5:    b = 8'h4F;
      3'd6:    b = 8'h4B;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/register_map_read_responder.sv =====
// Top level of the register map read responder: request decode, response sequencer,
// and the two table memories (bit tables and word tables). Depends on rmr_pkg and rmr_ram.
//
// A request is taken when start_i is high and busy_o is low. Loads write one table
// entry in the cycle they are taken and leave busy_o low, so loads may follow each other
// every cycle. A read, diagnostic or rejected request raises busy_o and answers with one
// word per strobe_o cycle, which the receiver must take as it comes. The byte count word
// appears in the cycle after the request; a word read then yields one payload word per
// cycle, while a bit read first passes through ST_PRIME to prime the memory read before
// streaming one payload word per cycle. Table contents are undefined until loaded.
module register_map_read_responder #(
  parameter int ADDRESS_BITS      = 16,
  parameter int MAX_PAYLOAD_BYTES = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  action_i,
  input  logic [15:0] address_i,
  input  logic [15:0] count_i,
  input  logic [15:0] load_value_i,
  output logic        strobe_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic        error_o
);

  localparam int BIDX_W = ADDRESS_BITS - 3;
  localparam int BRAM_DEPTH = 2 ** (BIDX_W + 1);
  localparam int WRAM_DEPTH = 2 ** (ADDRESS_BITS + 1);
  localparam logic [16:0] TABLE_SPAN = 17'(1) << ADDRESS_BITS;
  localparam logic [16:0] MAX_BYTES = 17'(MAX_PAYLOAD_BYTES);

  rmr_pkg::state_e state_q, state_d;

  logic              err_q, err_d;
  logic              bits_q, bits_d;
  logic              tsel_q, tsel_d;
  logic [5:0]        nbytes_q, nbytes_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [BIDX_W-1:0] bidx_q, bidx_d;
  logic [ADDRESS_BITS-1:0] widx_q, widx_d;
  logic [2:0]        shift_q, shift_d;
  logic [2:0]        tail_q, tail_d;
  logic [7:0]        prev_q, prev_d;

  logic        accept;
  logic        range_bad;
  logic [16:0] nb_bits;
  logic [16:0] nb_words;

  logic              bram_we, bram_re;
  logic [BIDX_W:0]   bram_waddr;
  logic [7:0]        bram_rdata;
  logic              wram_we, wram_re;
  logic [ADDRESS_BITS:0] wram_waddr;
  logic [15:0]       wram_rdata;

  logic [15:0] bit_pair;
  logic [7:0]  tail_mask;
  logic [7:0]  bit_byte;

  assign accept    = start_i && (state_q == rmr_pkg::ST_IDLE);
  assign range_bad = ({1'b0, address_i} + {1'b0, count_i}) > TABLE_SPAN;
  assign nb_bits   = ({1'b0, count_i} + 17'd7) >> 3;
  assign nb_words  = {count_i, 1'b0};

  // table writes happen in the cycle the load is taken
  always_comb begin
    bram_we    = 1'b0;
    wram_we    = 1'b0;
    bram_waddr = {(action_i == rmr_pkg::ACT_LD_DISC), address_i[BIDX_W-1:0]};
    wram_waddr = {(action_i == rmr_pkg::ACT_LD_INPUT), address_i[ADDRESS_BITS-1:0]};
    if (accept) begin
      case (action_i) inside
        rmr_pkg::ACT_LD_COIL, rmr_pkg::ACT_LD_DISC:   bram_we = 1'b1;
        rmr_pkg::ACT_LD_HOLD, rmr_pkg::ACT_LD_INPUT:  wram_we = 1'b1;
        default: ;
      endcase
    end
  end

  rmr_ram #(
    .WIDTH(8),
    .DEPTH(BRAM_DEPTH)
  ) u_bit_ram (
    .clk_i   (clk_i),
    .we_i    (bram_we),
    .waddr_i (bram_waddr),
    .wdata_i (load_value_i[7:0]),
    .re_i    (bram_re),
    .raddr_i ({tsel_q, bidx_q}),
    .rdata_o (bram_rdata)
  );

  rmr_ram #(
    .WIDTH(16),
    .DEPTH(WRAM_DEPTH)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (wram_we),
    .waddr_i (wram_waddr),
    .wdata_i (load_value_i),
    .re_i    (wram_re),
    .raddr_i ({tsel_q, widx_q}),
    .rdata_o (wram_rdata)
  );

  // bit repacking: window of two table bytes shifted by the bit offset
  assign bit_pair  = {prev_q, bram_rdata} << shift_q;
  assign tail_mask = (tail_q == 3'd0) ? 8'hFF : ~(8'hFF >> tail_q);
  assign bit_byte  = (cnt_q == 6'd1) ? (bit_pair[15:8] & tail_mask) : bit_pair[15:8];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmr_pkg::ST_IDLE: begin
        if (accept) begin
          case (action_i) inside
            rmr_pkg::ACT_RD_COIL, rmr_pkg::ACT_RD_DISC,
            rmr_pkg::ACT_RD_HOLD, rmr_pkg::ACT_RD_INPUT: state_d = rmr_pkg::ST_HDR;
            rmr_pkg::ACT_DIAG:                           state_d = rmr_pkg::ST_DIAG;
            default: ;
          endcase
        end
      end
      rmr_pkg::ST_HDR: begin
        if (err_q || nbytes_q == 6'd0) begin
          state_d = rmr_pkg::ST_IDLE;
        end else if (bits_q) begin
          state_d = rmr_pkg::ST_PRIME;
        end else begin
          state_d = rmr_pkg::ST_WHI;
        end
      end
      rmr_pkg::ST_PRIME: state_d = rmr_pkg::ST_BITS;
      rmr_pkg::ST_BITS: begin
        if (cnt_q == 6'd1) begin
          state_d = rmr_pkg::ST_IDLE;
        end
      end
      rmr_pkg::ST_WHI: state_d = rmr_pkg::ST_WLO;
      rmr_pkg::ST_WLO: begin
        state_d = (cnt_q == 6'd1) ? rmr_pkg::ST_IDLE : rmr_pkg::ST_WHI;
      end
      rmr_pkg::ST_DIAG: begin
        if (cnt_q[2:0] == rmr_pkg::DIAG_LAST) begin
          state_d = rmr_pkg::ST_IDLE;
        end
      end
      default: state_d = rmr_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory reads
  always_comb begin
    busy_o     = (state_q != rmr_pkg::ST_IDLE);
    strobe_o   = 1'b0;
    out_byte_o = 8'h00;
    last_o     = 1'b0;
    error_o    = 1'b0;
    bram_re    = 1'b0;
    wram_re    = 1'b0;
    unique case (state_q)
      rmr_pkg::ST_IDLE: ;
      rmr_pkg::ST_HDR: begin
        strobe_o   = 1'b1;
        out_byte_o = err_q ? 8'h00 : {2'b00, nbytes_q};
        last_o     = err_q || (nbytes_q == 6'd0);
        error_o    = err_q;
        bram_re    = bits_q;
        wram_re    = !bits_q;
      end
      rmr_pkg::ST_PRIME: bram_re = 1'b1;
      rmr_pkg::ST_BITS: begin
        strobe_o   = 1'b1;
        out_byte_o = bit_byte;
        last_o     = (cnt_q == 6'd1);
        bram_re    = 1'b1;
      end
      rmr_pkg::ST_WHI: begin
        strobe_o   = 1'b1;
        out_byte_o = wram_rdata[15:8];
      end
      rmr_pkg::ST_WLO: begin
        strobe_o   = 1'b1;
        out_byte_o = wram_rdata[7:0];
        last_o     = (cnt_q == 6'd1);
        wram_re    = 1'b1;
      end
      rmr_pkg::ST_DIAG: begin
        strobe_o   = 1'b1;
        out_byte_o = rmr_pkg::diag_byte(cnt_q[2:0]);
        last_o     = (cnt_q[2:0] == rmr_pkg::DIAG_LAST);
      end
      default: ;
    endcase
  end

  // request registers and stream counters
  always_comb begin
    err_d    = err_q;
    bits_d   = bits_q;
    tsel_d   = tsel_q;
    nbytes_d = nbytes_q;
    cnt_d    = cnt_q;
    bidx_d   = bidx_q;
    widx_d   = widx_q;
    shift_d  = shift_q;
    tail_d   = tail_q;
    prev_d   = prev_q;
    unique case (state_q)
      rmr_pkg::ST_IDLE: begin
        if (accept) begin
          bits_d  = (action_i == rmr_pkg::ACT_RD_COIL) || (action_i == rmr_pkg::ACT_RD_DISC);
          tsel_d  = action_i[0];
          bidx_d  = address_i[ADDRESS_BITS-1:3];
          widx_d  = address_i[ADDRESS_BITS-1:0];
          shift_d = address_i[2:0];
          tail_d  = count_i[2:0];
          cnt_d   = 6'd0;
          if (bits_d) begin
            err_d    = range_bad || (nb_bits > MAX_BYTES);
            nbytes_d = nb_bits[5:0];
          end else begin
            err_d    = range_bad || (nb_words > MAX_BYTES);
            nbytes_d = nb_words[5:0];
          end
        end
      end
      rmr_pkg::ST_HDR: begin
        cnt_d = nbytes_q;
        if (bits_q) begin
          bidx_d = bidx_q + BIDX_W'(1);
        end else begin
          widx_d = widx_q + ADDRESS_BITS'(1);
        end
      end
      rmr_pkg::ST_PRIME: begin
        prev_d = bram_rdata;
        bidx_d = bidx_q + BIDX_W'(1);
      end
      rmr_pkg::ST_BITS: begin
        prev_d = bram_rdata;
        bidx_d = bidx_q + BIDX_W'(1);
        cnt_d  = cnt_q - 6'd1;
      end
      rmr_pkg::ST_WHI: cnt_d = cnt_q - 6'd1;
      rmr_pkg::ST_WLO: begin
        cnt_d  = cnt_q - 6'd1;
        widx_d = widx_q + ADDRESS_BITS'(1);
      end
      rmr_pkg::ST_DIAG: cnt_d = cnt_q + 6'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmr_pkg::ST_IDLE;
      cnt_q   <= 6'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q    <= err_d;
    bits_q   <= bits_d;
    tsel_q   <= tsel_d;
    nbytes_q <= nbytes_d;
    bidx_q   <= bidx_d;
    widx_q   <= widx_d;
    shift_q  <= shift_d;
    tail_q   <= tail_d;
    prev_q   <= prev_d;
  end

`ifndef SYNTHESIS
  // response words only while a request is open
  assert property (@(posedge clk_i) disable iff (!rst_ni) strobe_o |-> busy_o)
    else $error("response word outside a request");

  assert property (@(posedge clk_i) disable iff (!rst_ni) error_o |-> (strobe_o && last_o))
    else $error("error word is not a single final word");

  // the final word closes the response
  assert property (@(posedge clk_i) disable iff (!rst_ni) (strobe_o && last_o) |=> !busy_o)
    else $error("still busy after final word");

  // every read or diagnostic request opens a response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (action_i <= rmr_pkg::ACT_DIAG)) |=> (busy_o && strobe_o))
    else $error("request taken without a response");
`endif

endmodule

// ===== rtl/rmr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the bit tables and the word tables of the responder.
// No dependencies.
module rmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/rmr_response_checker.sv =====
`timescale 1ns / 100ps
// Response checker for the register map read responder testbench: keeps its own copy of
// the four tables, predicts every response word of each accepted request and compares.
// Depends on rmr_pkg for the action codes.
module rmr_response_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [3:0]  action_i,
  input  logic [15:0] address_i,
  input  logic [15:0] count_i,
  input  logic [15:0] load_value_i,
  input  logic        strobe_i,
  input  logic [7:0]  out_byte_i,
  input  logic        last_i,
  input  logic        error_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int          WORD_DEPTH   = 65536;
  localparam int          BYTE_DEPTH   = WORD_DEPTH / 8;
  localparam int          MAX_PAYLOAD  = 63;
  localparam logic [7:0]  DIAG_COUNT   = 8'd8;
  localparam logic [47:0] DIAG_TEXT    = "All OK";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } resp_word_t;

  logic [7:0]  coil_tbl [BYTE_DEPTH];
  logic [7:0]  disc_tbl [BYTE_DEPTH];
  logic [15:0] hold_tbl [WORD_DEPTH];
  logic [15:0] inp_tbl  [WORD_DEPTH];
  resp_word_t  reply_q  [$];

  function automatic void push_word(input logic [7:0] d, input logic l, input logic e);
    resp_word_t w;
    w.data = d;
    w.last = l;
    w.err  = e;
    reply_q.push_back(w);
  endfunction

  function automatic void predict_bits(input logic disc, input int first, input int cnt);
    logic [7:0] pay [MAX_PAYLOAD];
    logic [7:0] src;
    int         nbytes, a, i, k;
    nbytes = (cnt + 7) / 8;
    if (first + cnt > WORD_DEPTH || nbytes > MAX_PAYLOAD) begin
      push_word(8'd0, 1'b1, 1'b1);
      return;
    end
    for (i = 0; i < MAX_PAYLOAD; i++) pay[i] = 8'd0;
    // lowest address lands in the msb of each byte
    for (k = 0; k < cnt; k++) begin
      a   = first + k;
      src = disc ? disc_tbl[a / 8] : coil_tbl[a / 8];
      pay[k / 8][7 - k % 8] = src[7 - a % 8];
    end
    push_word(8'(nbytes), nbytes == 0, 1'b0);
    for (i = 0; i < nbytes; i++) push_word(pay[i], i + 1 == nbytes, 1'b0);
  endfunction

  function automatic void predict_words(input logic inp, input int first, input int cnt);
    logic [15:0] w;
    int          k;
    if (first + cnt > WORD_DEPTH || cnt * 2 > MAX_PAYLOAD) begin
      push_word(8'd0, 1'b1, 1'b1);
      return;
    end
    push_word(8'(cnt * 2), cnt == 0, 1'b0);
    for (k = 0; k < cnt; k++) begin
      w = inp ? inp_tbl[first + k] : hold_tbl[first + k];
      push_word(w[15:8], 1'b0, 1'b0);
      push_word(w[7:0], k + 1 == cnt, 1'b0);
    end
  endfunction

  function automatic void predict_request(input logic [3:0] act, input logic [15:0] addr,
                                          input logic [15:0] cnt, input logic [15:0] val);
    int i;
    case (act)
      rmr_pkg::ACT_RD_COIL:  predict_bits(1'b0, int'(addr), int'(cnt));
      rmr_pkg::ACT_RD_DISC:  predict_bits(1'b1, int'(addr), int'(cnt));
      rmr_pkg::ACT_RD_HOLD:  predict_words(1'b0, int'(addr), int'(cnt));
      rmr_pkg::ACT_RD_INPUT: predict_words(1'b1, int'(addr), int'(cnt));
      rmr_pkg::ACT_DIAG: begin
        push_word(DIAG_COUNT, 1'b0, 1'b0);
        for (i = 0; i < 6; i++) push_word(DIAG_TEXT[47 - 8 * i -: 8], i == 5, 1'b0);
      end
      // bit table loads take a byte index that wraps at the table depth
      rmr_pkg::ACT_LD_COIL:  coil_tbl[addr[12:0]] = val[7:0];
      rmr_pkg::ACT_LD_DISC:  disc_tbl[addr[12:0]] = val[7:0];
      rmr_pkg::ACT_LD_HOLD:  hold_tbl[addr] = val;
      rmr_pkg::ACT_LD_INPUT: inp_tbl[addr] = val;
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin
    resp_word_t want;
    if (rst_ni) begin
      if (strobe_i) begin
        if (reply_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected word, expected none, got byte %02h last %b error %b",
                   $time, out_byte_i, last_i, error_i);
        end else begin
          want = reply_q.pop_front();
          if (want.data !== out_byte_i || want.last !== last_i || want.err !== error_i) begin
            fail_count_o++;
            $display({"%0t: mismatch, expected byte %02h last %b error %b, ",
                      "got byte %02h last %b error %b"},
                     $time, want.data, want.last, want.err, out_byte_i, last_i, error_i);
          end
        end
      end
      if (start_i && !busy_i) predict_request(action_i, address_i, count_i, load_value_i);
    end
    pending_o <= reply_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the register map read responder: directed and random requests, with
// table loads ahead of valid reads, under several sender idling phases, and the verdict.
// Depends on rmr_pkg, register_map_read_responder and rmr_response_checker.
module tb;

  localparam int         WORD_DEPTH      = 65536;
  localparam int         BYTE_DEPTH      = WORD_DEPTH / 8;
  localparam int         MAX_BIT_COUNT   = 504;
  localparam int         MAX_WORD_COUNT  = 31;
  localparam int         IDLE_LIMIT      = 3000;
  localparam int         TAIL_CYCLES     = 80;
  localparam int         ITEMS_PER_PHASE = 45;
  localparam logic [3:0] ACT_UNUSED_LO   = 4'd9;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [3:0]  action;
  logic [15:0] address;
  logic [15:0] count;
  logic [15:0] load_value;
  logic        strobe;
  logic [7:0]  out_byte;
  logic        last;
  logic        error;

  int fail_count;
  int pending;
  int idle_pct;
  int quiet_cycles;
  int items_sent;
  bit loaded [4][WORD_DEPTH];

  register_map_read_responder uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_o       (busy),
    .action_i     (action),
    .address_i    (address),
    .count_i      (count),
    .load_value_i (load_value),
    .strobe_o     (strobe),
    .out_byte_o   (out_byte),
    .last_o       (last),
    .error_o      (error)
  );

  rmr_response_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .action_i     (action),
    .address_i    (address),
    .count_i      (count),
    .load_value_i (load_value),
    .strobe_i     (strobe),
    .out_byte_i   (out_byte),
    .last_i       (last),
    .error_i      (error),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // one request word, held until the block takes it
  task automatic send_word(input logic [3:0] act, input logic [15:0] addr, cnt, val);
    while ($urandom_range(99) < idle_pct) begin
      start      <= 1'b0;
      action     <= 4'($urandom);
      address    <= 16'($urandom);
      count      <= 16'($urandom);
      load_value <= 16'($urandom);
      @(posedge clk);
    end
    start      <= 1'b1;
    action     <= act;
    address    <= addr;
    count      <= cnt;
    load_value <= val;
    do @(posedge clk); while (busy);
    items_sent++;
    case (act)
      rmr_pkg::ACT_LD_COIL:  loaded[0][addr[12:0]] = 1'b1;
      rmr_pkg::ACT_LD_DISC:  loaded[1][addr[12:0]] = 1'b1;
      rmr_pkg::ACT_LD_HOLD:  loaded[2][addr] = 1'b1;
      rmr_pkg::ACT_LD_INPUT: loaded[3][addr] = 1'b1;
      default: ;
    endcase
  endtask

  // a valid read first loads every entry it touches that was never loaded, plus one beyond
  task automatic issue_request(input logic [3:0] act, input logic [15:0] addr, cnt, val);
    int         tab, depth, first, fin, idx, a, n;
    logic [3:0] ld_act;
    a      = int'(addr);
    n      = int'(cnt);
    tab    = -1;
    depth  = WORD_DEPTH;
    ld_act = rmr_pkg::ACT_LD_HOLD;
    case (act)
      rmr_pkg::ACT_RD_COIL: begin
        tab    = 0;
        depth  = BYTE_DEPTH;
        ld_act = rmr_pkg::ACT_LD_COIL;
      end
      rmr_pkg::ACT_RD_DISC: begin
        tab    = 1;
        depth  = BYTE_DEPTH;
        ld_act = rmr_pkg::ACT_LD_DISC;
      end
      rmr_pkg::ACT_RD_HOLD: begin
        tab    = 2;
        ld_act = rmr_pkg::ACT_LD_HOLD;
      end
      rmr_pkg::ACT_RD_INPUT: begin
        tab    = 3;
        ld_act = rmr_pkg::ACT_LD_INPUT;
      end
      default: ;
    endcase
    if (tab >= 0 && n > 0 && a + n <= WORD_DEPTH &&
        n <= (depth == BYTE_DEPTH ? MAX_BIT_COUNT : MAX_WORD_COUNT)) begin
      first = (depth == BYTE_DEPTH) ? a / 8 : a;
      fin   = (depth == BYTE_DEPTH) ? (a + n - 1) / 8 + 1 : a + n;
      for (idx = first; idx <= fin; idx++) begin
        if (!loaded[tab][idx % depth])
          send_word(ld_act,
                    16'(idx % depth + (depth == BYTE_DEPTH ? BYTE_DEPTH * $urandom_range(7) : 0)),
                    16'($urandom), 16'($urandom));
      end
    end
    send_word(act, addr, cnt, val);
  endtask

  task automatic random_request();
    int         sel, tab, a, c;
    logic [3:0] act;
    logic [3:0] ld_act;
    sel = $urandom_range(99);
    tab = $urandom_range(3);
    case (tab)
      0: begin
        act    = rmr_pkg::ACT_RD_COIL;
        ld_act = rmr_pkg::ACT_LD_COIL;
      end
      1: begin
        act    = rmr_pkg::ACT_RD_DISC;
        ld_act = rmr_pkg::ACT_LD_DISC;
      end
      2: begin
        act    = rmr_pkg::ACT_RD_HOLD;
        ld_act = rmr_pkg::ACT_LD_HOLD;
      end
      default: begin
        act    = rmr_pkg::ACT_RD_INPUT;
        ld_act = rmr_pkg::ACT_LD_INPUT;
      end
    endcase
    if (sel < 70) begin
      if (tab < 2) begin
        case ($urandom_range(9))
          0: c = $urandom_range(1) ? MAX_BIT_COUNT : $urandom_range(400, MAX_BIT_COUNT);
          1: c = 0;
          default: c = $urandom_range(1, 40);
        endcase
      end else begin
        case ($urandom_range(9))
          0: c = $urandom_range(1) ? MAX_WORD_COUNT : $urandom_range(24, MAX_WORD_COUNT);
          1: c = 0;
          default: c = $urandom_range(1, 6);
        endcase
      end
      case ($urandom_range(9))
        0: a = 0;
        1: a = WORD_DEPTH - c;
        2, 3: a = $urandom_range(0, WORD_DEPTH - c);
        default: a = $urandom_range(0, tab < 2 ? 300 : 60);
      endcase
      issue_request(act, 16'(a), 16'(c), 16'($urandom));
    end else if (sel < 78) begin
      issue_request(rmr_pkg::ACT_DIAG, 16'($urandom), 16'($urandom), 16'($urandom));
    end else if (sel < 86) begin
      // range runs past the end of the table
      a = $urandom_range(2, WORD_DEPTH - 1);
      c = $urandom_range(WORD_DEPTH + 1 - a, WORD_DEPTH - 1);
      issue_request(act, 16'(a), 16'(c), 16'($urandom));
    end else if (sel < 93) begin
      // payload too large for one response
      c = (tab < 2) ? $urandom_range(MAX_BIT_COUNT + 1, 4000)
                    : $urandom_range(MAX_WORD_COUNT + 1, 2000);
      a = $urandom_range(0, WORD_DEPTH - c);
      issue_request(act, 16'(a), 16'(c), 16'($urandom));
    end else if (sel < 97) begin
      issue_request(ACT_UNUSED_LO + 4'($urandom_range(6)), 16'($urandom), 16'($urandom),
                    16'($urandom));
    end else begin
      issue_request(ld_act, 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int phase_pct [3] = '{0, 71, 9};
    int phase_end;
    rst_n      = 1'b0;
    idle_pct   = 0;
    items_sent = 0;
    start      <= 1'b0;
    action     <= rmr_pkg::ACT_RD_COIL;
    address    <= 16'd0;
    count      <= 16'd0;
    load_value <= 16'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // load index wrap, table ends, zero count, max sizes, bad ranges, unused codes
    issue_request(rmr_pkg::ACT_LD_COIL,  16'hFFFF,  16'h0000,  16'hFF5A);
    issue_request(rmr_pkg::ACT_LD_DISC,  16'hE000,  16'hFFFF,  16'h00A5);
    issue_request(rmr_pkg::ACT_LD_HOLD,  16'hFFFF,  16'h0000,  16'hFFFF);
    issue_request(rmr_pkg::ACT_LD_INPUT, 16'h0000,  16'hFFFF,  16'h0000);
    issue_request(rmr_pkg::ACT_RD_COIL,  16'd0,     16'd0,     16'hFFFF);
    issue_request(rmr_pkg::ACT_RD_COIL,  16'd65535, 16'd1,     16'h0000);
    issue_request(rmr_pkg::ACT_RD_DISC,  16'd65528, 16'd8,     16'h0000);
    issue_request(rmr_pkg::ACT_RD_DISC,  16'd3,     16'd13,    16'h0000);
    issue_request(rmr_pkg::ACT_RD_HOLD,  16'd65535, 16'd1,     16'h0000);
    issue_request(rmr_pkg::ACT_RD_INPUT, 16'd0,     16'd2,     16'h0000);
    issue_request(rmr_pkg::ACT_RD_HOLD,  16'd0,     16'd0,     16'h0000);
    issue_request(rmr_pkg::ACT_DIAG,     16'hFFFF,  16'hFFFF,  16'hFFFF);
    issue_request(rmr_pkg::ACT_DIAG,     16'h0000,  16'h0000,  16'h0000);
    issue_request(rmr_pkg::ACT_RD_COIL,  16'd65535, 16'd2,     16'h0000);
    issue_request(rmr_pkg::ACT_RD_INPUT, 16'd1,     16'd65535, 16'h0000);
    issue_request(rmr_pkg::ACT_RD_HOLD,  16'hFFFF,  16'hFFFF,  16'hFFFF);
    issue_request(rmr_pkg::ACT_RD_DISC,  16'd0,     16'd505,   16'h0000);
    issue_request(rmr_pkg::ACT_RD_HOLD,  16'd0,     16'd32,    16'h0000);
    issue_request(rmr_pkg::ACT_RD_INPUT, 16'd0,     16'd31,    16'h0000);
    issue_request(4'hF,                  16'hFFFF,  16'hFFFF,  16'hFFFF);
    issue_request(ACT_UNUSED_LO,         16'h0000,  16'h0000,  16'h0000);

    foreach (phase_pct[p]) begin
      idle_pct  = phase_pct[p];
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) random_request();
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
